// ===== rtl/core/msta_pkg.sv =====
// Shared types and constants of the multi-stream timestamp aligner.
`timescale 1ns / 1ps

package msta_pkg;

   // Fixed field widths
   localparam int STAMP_W    = 48;
   localparam int IN_PAY_W   = 32;
   localparam int OUT_PAY_W  = 32;
   localparam int CLIENT_W   = 3;
   localparam int MODE_W     = 2;
   localparam int DROP_W     = 8;
   localparam int HW_W       = 32;
   localparam int CIU_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 96;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIENTS     = 2'd1;

   // Reset values of the registers
   localparam logic [HW_W-1:0]  HALF_WINDOW_RST = 32'd16;
   localparam logic [CIU_W-1:0] CLIENTS_RST     = 4'd8;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT  = 2'd0,
      MODE_PICK    = 2'd1,
      MODE_REFRESH = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ORDER = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_RD,
      S_INS_CHK,
      S_PICK_RD,
      S_PICK_OUT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DROP_RD,
      S_DROP_CMP,
      S_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic       idx_clear;
      logic       idx_inc;
      logic       rd_head;
      logic       rd_tail;
      logic       ins_check;
      logic       pick_take;
      logic       set_status;
      status_type status_code;
      logic       latest_upd;
      logic       drop_pop;
      logic       out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              client_ok;
      logic              fill_zero;
      logic              scan_done;
      logic              stale;
   } sts_type;

endpackage

// ===== rtl/core/msta_dp.sv =====
// Datapath: queue memories, per-client pointers, registers and result register.
`timescale 1ns / 1ps

module msta_dp #(
   parameter int NUM_CLIENTS  = 8,
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [msta_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [msta_pkg::MODE_W-1:0]          req_tuser,
   input  logic                                 csr_we,
   input  logic [msta_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msta_pkg::CSR_DATA_W-1:0]      csr_data,
   input  msta_pkg::cmd_type                    cmd,
   output msta_pkg::sts_type                    sts,
   output logic [msta_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int SEL_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam int CNT_W  = $clog2(NUM_CLIENTS + 1);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRIES = NUM_CLIENTS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int STAMP_W = msta_pkg::STAMP_W;

   // Captured request
   logic [msta_pkg::MODE_W-1:0]   mode_ff;
   logic [msta_pkg::CLIENT_W-1:0] client_ff;
   logic [STAMP_W-1:0]            stamp_ff;
   logic [PAYLOAD_BITS-1:0]       pay_ff;

   // Registers
   logic [msta_pkg::HW_W-1:0]  hw_ff;
   logic [msta_pkg::CIU_W-1:0] ciu_ff;

   // Walk index and per-client queue state
   logic [CNT_W-1:0]  idx_ff;
   logic [PTR_W-1:0]  rp_ff [NUM_CLIENTS];
   logic [PTR_W-1:0]  wp_ff [NUM_CLIENTS];
   logic [FILL_W-1:0] fill_ff [NUM_CLIENTS];

   // Queue memories
   logic [STAMP_W-1:0]      stamp_mem [ENTRIES];
   logic [PAYLOAD_BITS-1:0] pay_mem [ENTRIES];
   logic [STAMP_W-1:0]      rd_stamp_ff;
   logic [PAYLOAD_BITS-1:0] rd_pay_ff;

   // Work results
   logic [STAMP_W-1:0]                 latest_ff;
   logic [1:0]                         res_status_ff;
   logic [STAMP_W-1:0]                 res_stamp_ff;
   logic [msta_pkg::OUT_PAY_W-1:0]     res_pay_ff;
   logic [msta_pkg::DROP_W-1:0]        res_drop_ff;
   logic [msta_pkg::RSP_DATA_W-1:0]    rsp_data_ff;

   logic [SEL_W-1:0]  sel;
   logic [PTR_W-1:0]  rp_cur, wp_cur, tail_ptr, rp_nxt, wp_nxt;
   logic [FILL_W-1:0] fill_cur;
   logic [ADDR_W-1:0] base, rd_addr, wr_addr;
   logic              older, full, ins_ok, wr_en, rd_en, pop;
   logic [31:0]       n_eff;
   logic              ready_all;
   logic [STAMP_W:0]  head_plus;

   assign sel      = idx_ff[SEL_W-1:0];
   assign rp_cur   = rp_ff[sel];
   assign wp_cur   = wp_ff[sel];
   assign fill_cur = fill_ff[sel];
   assign tail_ptr = (wp_cur == '0) ? PTR_W'(QUEUE_DEPTH - 1) : wp_cur - 1'b1;
   assign rp_nxt   = (int'(rp_cur) == QUEUE_DEPTH - 1) ? '0 : rp_cur + 1'b1;
   assign wp_nxt   = (int'(wp_cur) == QUEUE_DEPTH - 1) ? '0 : wp_cur + 1'b1;
   assign base     = ADDR_W'(int'(sel) * QUEUE_DEPTH);
   assign rd_addr  = base + ADDR_W'(cmd.rd_tail ? tail_ptr : rp_cur);
   assign wr_addr  = base + ADDR_W'(wp_cur);

   // Insert checks against the tail just read
   assign older  = (fill_cur != '0) && (rd_stamp_ff >= stamp_ff);
   assign full   = (int'(fill_cur) >= QUEUE_DEPTH);
   assign ins_ok = !older && !full;
   assign wr_en  = cmd.ins_check && ins_ok;
   assign rd_en  = cmd.rd_head || cmd.rd_tail;
   assign pop    = cmd.pick_take || cmd.drop_pop;

   // Clients taking part, limited to the number built
   assign n_eff = (int'(ciu_ff) > NUM_CLIENTS) ? NUM_CLIENTS : int'(ciu_ff);

   // Stale test: head + half window below latest
   assign head_plus = {1'b0, rd_stamp_ff} + (STAMP_W + 1)'(hw_ff);

   always_comb begin
      ready_all = 1'b1;
      for (int i = 0; i < NUM_CLIENTS; i++) begin
         if (i < n_eff && fill_ff[i] == '0) begin
            ready_all = 1'b0;
         end
      end
   end

   assign sts.mode      = mode_ff;
   assign sts.client_ok = (int'(client_ff) < NUM_CLIENTS);
   assign sts.fill_zero = (fill_cur == '0);
   assign sts.scan_done = (int'(idx_ff) >= n_eff);
   assign sts.stale     = (head_plus < {1'b0, latest_ff});

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff  <= msta_pkg::HALF_WINDOW_RST;
         ciu_ff <= msta_pkg::CLIENTS_RST;
      end else if (csr_we) begin
         if (csr_index == msta_pkg::CSR_HALF_WINDOW) begin
            hw_ff <= csr_data;
         end else if (csr_index == msta_pkg::CSR_CLIENTS) begin
            ciu_ff <= csr_data[msta_pkg::CIU_W-1:0];
         end
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_tuser;
         client_ff <= req_tdata[2:0];
         stamp_ff  <= req_tdata[50:3];
         pay_ff    <= PAYLOAD_BITS'(req_tdata[82:51]);
      end
   end

   // Walk index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.load) begin
         idx_ff <= CNT_W'(req_tdata[2:0]);
      end else if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Per-client pointers and fill counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLIENTS; i++) begin
            rp_ff[i]   <= '0;
            wp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else if (wr_en) begin
         wp_ff[sel]   <= wp_nxt;
         fill_ff[sel] <= fill_cur + 1'b1;
      end else if (pop) begin
         rp_ff[sel]   <= rp_nxt;
         fill_ff[sel] <= fill_cur - 1'b1;
      end
   end

   // Queue memories, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_mem[wr_addr] <= stamp_ff;
         pay_mem[wr_addr]   <= pay_ff;
      end
      if (rd_en) begin
         rd_stamp_ff <= stamp_mem[rd_addr];
         rd_pay_ff   <= pay_mem[rd_addr];
      end
   end

   // Per-item results
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_status_ff <= msta_pkg::ST_OK;
         res_stamp_ff  <= '0;
         res_pay_ff    <= '0;
         res_drop_ff   <= '0;
         latest_ff     <= '0;
      end else begin
         if (cmd.set_status) begin
            res_status_ff <= cmd.status_code;
         end
         if (cmd.ins_check) begin
            res_status_ff <= older ? msta_pkg::ST_ORDER :
                             full  ? msta_pkg::ST_FULL  : msta_pkg::ST_OK;
         end
         if (cmd.pick_take) begin
            res_stamp_ff <= rd_stamp_ff;
            res_pay_ff   <= msta_pkg::OUT_PAY_W'(rd_pay_ff);
         end
         if (cmd.latest_upd && rd_stamp_ff > latest_ff) begin
            latest_ff <= rd_stamp_ff;
         end
         if (cmd.drop_pop) begin
            res_drop_ff <= res_drop_ff + 1'b1;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {5'd0, res_drop_ff,
                         (mode_ff == msta_pkg::MODE_REFRESH) && ready_all,
                         res_pay_ff, res_stamp_ff, res_status_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== rtl/core/msta_ctrl.sv =====
// Controller: sequences insert, pick and refresh over the datapath.
`timescale 1ns / 1ps

module msta_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  msta_pkg::sts_type  sts,
   output msta_pkg::cmd_type  cmd
);

   msta_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msta_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == msta_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.status_code = msta_pkg::ST_OK;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         msta_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = msta_pkg::S_DISPATCH;
            end
         end
         msta_pkg::S_DISPATCH: begin
            case (sts.mode)
               msta_pkg::MODE_INSERT: begin
                  if (!sts.client_ok) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = msta_pkg::ST_FULL;
                     state_in        = msta_pkg::S_FINISH;
                  end else begin
                     state_in = msta_pkg::S_INS_RD;
                  end
               end
               msta_pkg::MODE_PICK: begin
                  if (!sts.client_ok || sts.fill_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = msta_pkg::ST_EMPTY;
                     state_in        = msta_pkg::S_FINISH;
                  end else begin
                     state_in = msta_pkg::S_PICK_RD;
                  end
               end
               msta_pkg::MODE_REFRESH: begin
                  cmd.idx_clear = 1'b1;
                  state_in      = msta_pkg::S_SCAN_RD;
               end
               default: state_in = msta_pkg::S_FINISH;
            endcase
         end
         msta_pkg::S_INS_RD: begin
            cmd.rd_tail = 1'b1;
            state_in    = msta_pkg::S_INS_CHK;
         end
         msta_pkg::S_INS_CHK: begin
            cmd.ins_check = 1'b1;
            state_in      = msta_pkg::S_FINISH;
         end
         msta_pkg::S_PICK_RD: begin
            cmd.rd_head = 1'b1;
            state_in    = msta_pkg::S_PICK_OUT;
         end
         msta_pkg::S_PICK_OUT: begin
            cmd.pick_take = 1'b1;
            state_in      = msta_pkg::S_FINISH;
         end
         // First pass: latest head stamp
         msta_pkg::S_SCAN_RD: begin
            if (sts.scan_done) begin
               cmd.idx_clear = 1'b1;
               state_in      = msta_pkg::S_DROP_RD;
            end else if (sts.fill_zero) begin
               cmd.idx_inc = 1'b1;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = msta_pkg::S_SCAN_CMP;
            end
         end
         msta_pkg::S_SCAN_CMP: begin
            cmd.latest_upd = 1'b1;
            cmd.idx_inc    = 1'b1;
            state_in       = msta_pkg::S_SCAN_RD;
         end
         // Second pass: drop stale heads per client
         msta_pkg::S_DROP_RD: begin
            if (sts.scan_done) begin
               state_in = msta_pkg::S_FINISH;
            end else if (sts.fill_zero) begin
               cmd.idx_inc = 1'b1;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = msta_pkg::S_DROP_CMP;
            end
         end
         msta_pkg::S_DROP_CMP: begin
            if (sts.stale) begin
               cmd.drop_pop = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
            state_in = msta_pkg::S_DROP_RD;
         end
         msta_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = msta_pkg::S_IDLE;
            end
         end
         default: state_in = msta_pkg::S_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/multi_stream_timestamp_aligner.sv =====
// Top level of the multi-stream timestamp aligner.
//
//   channel | direction | contents
//   req_    | in        | tuser: mode; tdata: client, stamp, payload
//   rsp_    | out       | tdata: status, out_stamp, out_payload, all_ready, stale_dropped
//   csr_    | in        | index 0 half_window, index 1 clients_in_use
//
// Insert and pick go from accept through dispatch, a queue read and a check or a take
// to the result load; a pick on an empty queue and an unknown mode go from dispatch
// straight to the result load. Refresh walks the clients in use twice, for the latest
// head stamp and to drop stale heads, reading heads via the queue memory's one read port.
// One item is in work at a time; the output register lets the next item be
// accepted while a result waits, and a finished item stalls until that
// register is free. Reset is synchronous and empties all queues.
`timescale 1ns / 1ps

module multi_stream_timestamp_aligner #(
   parameter int NUM_CLIENTS  = 8,
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // client[2:0], stamp[50:3], payload[82:51], zeros
   input  logic [msta_pkg::REQ_DATA_W-1:0]      req_tdata,
   // mode[1:0]
   input  logic [msta_pkg::MODE_W-1:0]          req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // status[1:0], out_stamp[49:2], out_payload[81:50], all_ready[82],
   // stale_dropped[90:83], zeros
   output logic [msta_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [msta_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msta_pkg::CSR_DATA_W-1:0]      csr_data
);

   msta_pkg::cmd_type cmd;
   msta_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   msta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   msta_dp #(
      .NUM_CLIENTS  (NUM_CLIENTS),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/core/msta_checker.sv =====
// Port-level checker of the aligner, bound to the top level.
`timescale 1ns / 1ps

module msta_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [msta_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its data
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // An accepted item yields no result in the very next cycle
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result without work");

endmodule

bind multi_stream_timestamp_aligner msta_checker u_msta_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb_multi_stream_timestamp_aligner.sv =====
// Self-checking testbench for the multi-stream timestamp aligner.
`timescale 1ns / 1ps

module tb_multi_stream_timestamp_aligner;

   localparam int NCLI = 8;
   localparam int QDEPTH = 16;
   localparam int RAND_PER_PHASE = 260;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 200;
   localparam logic [msta_pkg::MODE_W-1:0] MODE_UNKNOWN = 2'd3;
   localparam logic [msta_pkg::STAMP_W-1:0] STAMP_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      msta_pkg::status_type                 status;
      logic [msta_pkg::STAMP_W-1:0]         stamp;
      logic [msta_pkg::OUT_PAY_W-1:0]       pay;
      logic                                 ready;
      logic [msta_pkg::DROP_W-1:0]          dropped;
   } result_type;

   typedef struct {
      logic [msta_pkg::MODE_W-1:0]   mode;
      logic [msta_pkg::CLIENT_W-1:0] client;
      logic [msta_pkg::STAMP_W-1:0]  stamp;
      logic [msta_pkg::IN_PAY_W-1:0] pay;
      bit                            typed;
      result_type                    res;
   } row_type;

   logic clock;
   logic reset;
   logic req_tvalid, req_tready;
   logic [msta_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [msta_pkg::MODE_W-1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [msta_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [msta_pkg::CSR_IDX_W-1:0] csr_index;
   logic [msta_pkg::CSR_DATA_W-1:0] csr_data;

   multi_stream_timestamp_aligner u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the per-client queues and the registers
   logic [msta_pkg::STAMP_W-1:0]  sh_stamp [NCLI][QDEPTH];
   logic [msta_pkg::IN_PAY_W-1:0] sh_pay [NCLI][QDEPTH];
   int unsigned sh_rd [NCLI];
   int unsigned sh_wr [NCLI];
   int unsigned sh_fill [NCLI];
   logic [msta_pkg::HW_W-1:0]  sh_half_window;
   logic [msta_pkg::CIU_W-1:0] sh_clients;

   result_type pending_results [$];
   row_type    directed_rows [$];
   logic [msta_pkg::STAMP_W-1:0] last_stamp [NCLI];

   int  errors = 0;
   int  items_sent = 0;
   int  status_seen [4];
   int  stale_total = 0;
   bit  quiet = 0;
   bit  hold_request = 0;
   int  idle_cycles = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Model of one operation; updates the shadow state
   function automatic result_type align_step(logic [msta_pkg::MODE_W-1:0] mode,
                                             logic [msta_pkg::CLIENT_W-1:0] c,
                                             logic [msta_pkg::STAMP_W-1:0] stamp,
                                             logic [msta_pkg::IN_PAY_W-1:0] pay);
      result_type r;
      int unsigned n;
      int unsigned tp;
      logic [msta_pkg::STAMP_W-1:0] latest;
      logic [msta_pkg::STAMP_W-1:0] head;
      r = '0;
      r.status = msta_pkg::ST_OK;
      case (mode)
         msta_pkg::MODE_INSERT: begin
            if (sh_fill[c] != 0) begin
               tp = (sh_wr[c] + QDEPTH - 1) % QDEPTH;
               if (sh_stamp[c][tp] >= stamp) r.status = msta_pkg::ST_ORDER;
            end
            if (r.status == msta_pkg::ST_OK && sh_fill[c] >= QDEPTH)
               r.status = msta_pkg::ST_FULL;
            if (r.status == msta_pkg::ST_OK) begin
               sh_stamp[c][sh_wr[c]] = stamp;
               sh_pay[c][sh_wr[c]] = pay;
               sh_wr[c] = (sh_wr[c] + 1) % QDEPTH;
               sh_fill[c]++;
            end
         end
         msta_pkg::MODE_PICK: begin
            if (sh_fill[c] == 0) begin
               r.status = msta_pkg::ST_EMPTY;
            end else begin
               r.stamp = sh_stamp[c][sh_rd[c]];
               r.pay = sh_pay[c][sh_rd[c]];
               sh_rd[c] = (sh_rd[c] + 1) % QDEPTH;
               sh_fill[c]--;
            end
         end
         msta_pkg::MODE_REFRESH: begin
            n = (sh_clients > NCLI) ? NCLI : sh_clients;
            latest = '0;
            for (int i = 0; i < n; i++) begin
               if (sh_fill[i] != 0 && sh_stamp[i][sh_rd[i]] > latest)
                  latest = sh_stamp[i][sh_rd[i]];
            end
            // 64-bit sum: stamp plus window never wraps
            for (int i = 0; i < n; i++) begin
               while (sh_fill[i] != 0) begin
                  head = sh_stamp[i][sh_rd[i]];
                  if (64'(head) + 64'(sh_half_window) >= 64'(latest)) break;
                  sh_rd[i] = (sh_rd[i] + 1) % QDEPTH;
                  sh_fill[i]--;
                  r.dropped++;
               end
            end
            r.ready = 1'b1;
            for (int i = 0; i < n; i++)
               if (sh_fill[i] == 0) r.ready = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offer one item and wait for its transfer; valid stays high afterwards
   task automatic send_item(logic [msta_pkg::MODE_W-1:0] mode,
                            logic [msta_pkg::CLIENT_W-1:0] c,
                            logic [msta_pkg::STAMP_W-1:0] stamp,
                            logic [msta_pkg::IN_PAY_W-1:0] pay,
                            bit typed, result_type typed_res);
      result_type r;
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {5'b0, pay, stamp, c};
      do @(posedge clock); while (!req_tready);
      r = align_step(mode, c, stamp, pay);
      pending_results.push_back(typed ? typed_res : r);
      items_sent++;
   endtask

   task automatic sender_gap(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // One register write; the channel is then left idle before the task returns
   task automatic csr_write(logic [msta_pkg::CSR_IDX_W-1:0] idx,
                            logic [msta_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == msta_pkg::CSR_HALF_WINDOW) sh_half_window = value;
      else sh_clients = value[msta_pkg::CIU_W-1:0];
      @(posedge clock);
   endtask

   function automatic void add_row(logic [msta_pkg::MODE_W-1:0] mode,
                                   logic [msta_pkg::CLIENT_W-1:0] c,
                                   logic [msta_pkg::STAMP_W-1:0] stamp,
                                   logic [msta_pkg::IN_PAY_W-1:0] pay,
                                   bit typed, msta_pkg::status_type st,
                                   logic [msta_pkg::STAMP_W-1:0] os,
                                   logic [msta_pkg::OUT_PAY_W-1:0] op, logic rdy);
      row_type row;
      row.mode = mode;
      row.client = c;
      row.stamp = stamp;
      row.pay = pay;
      row.typed = typed;
      row.res = '{status: st, stamp: os, pay: op, ready: rdy, dropped: '0};
      directed_rows.push_back(row);
   endfunction

   // Response side: random stalls, one long hold on request, field checks
   initial begin
      int stall_cnt;
      result_type exp_r;
      result_type got;
      stall_cnt = 0;
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: msta_pkg::status_type'(rsp_tdata[1:0]),
                    stamp: rsp_tdata[49:2], pay: rsp_tdata[81:50],
                    ready: rsp_tdata[82], dropped: rsp_tdata[90:83]};
            if (pending_results.size() == 0) begin
               $display("%0t: result with nothing expected: %h", $time, rsp_tdata);
               errors++;
            end else begin
               exp_r = pending_results.pop_front();
               status_seen[got.status]++;
               stale_total += got.dropped;
               if (got.status !== exp_r.status) begin
                  $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                  errors++;
               end
               if (got.stamp !== exp_r.stamp) begin
                  $display("%0t: out_stamp exp %h got %h", $time, exp_r.stamp, got.stamp);
                  errors++;
               end
               if (got.pay !== exp_r.pay) begin
                  $display("%0t: out_payload exp %h got %h", $time, exp_r.pay, got.pay);
                  errors++;
               end
               if (got.ready !== exp_r.ready) begin
                  $display("%0t: all_ready exp %b got %b", $time, exp_r.ready, got.ready);
                  errors++;
               end
               if (got.dropped !== exp_r.dropped) begin
                  $display("%0t: stale_dropped exp %0d got %0d", $time, exp_r.dropped,
                           got.dropped);
                  errors++;
               end
            end
         end
         if (stall_cnt > 0) begin
            stall_cnt--;
            if (stall_cnt == 0) rsp_tready <= 1'b1;
         end else if (hold_request) begin
            hold_request = 0;
            stall_cnt = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (!quiet && !reset && $urandom_range(0, 9) == 0) begin
            stall_cnt = $urandom_range(1, 8);
            rsp_tready <= 1'b0;
         end
      end
   end

   // Watchdog: cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("tb: failure");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [msta_pkg::HW_W-1:0]  phase_hw [7];
      logic [msta_pkg::CIU_W-1:0] phase_ciu [7];
      logic [msta_pkg::MODE_W-1:0] mode;
      logic [msta_pkg::CLIENT_W-1:0] c;
      logic [msta_pkg::STAMP_W-1:0] stamp;
      logic [msta_pkg::STAMP_W-1:0] base;
      int pick;

      phase_hw = '{32'd16, 32'd0, 32'hFFFF_FFFF, 32'd100, 32'd0, 32'd5, 32'd1000};
      phase_ciu = '{4'd8, 4'd1, 4'd8, 4'd15, 4'd0, 4'd4, 4'd8};

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      for (int i = 0; i < NCLI; i++) begin
         sh_rd[i] = 0;
         sh_wr[i] = 0;
         sh_fill[i] = 0;
      end
      sh_half_window = msta_pkg::HALF_WINDOW_RST;
      sh_clients = msta_pkg::CLIENTS_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queues, ordering, extremes, unknown mode, full queue
      add_row(msta_pkg::MODE_PICK, 3'd0, '0, '0, 1, msta_pkg::ST_EMPTY, '0, '0, 1'b0);
      add_row(msta_pkg::MODE_REFRESH, 3'd0, '0, '0, 1, msta_pkg::ST_OK, '0, '0, 1'b0);
      add_row(msta_pkg::MODE_INSERT, 3'd0, 48'd100, 32'hFFFF_FFFF, 1, msta_pkg::ST_OK,
              '0, '0, 1'b0);
      add_row(msta_pkg::MODE_INSERT, 3'd0, 48'd100, 32'h1234_5678, 1, msta_pkg::ST_ORDER,
              '0, '0, 1'b0);
      add_row(msta_pkg::MODE_INSERT, 3'd7, STAMP_MAX, 32'h0, 1, msta_pkg::ST_OK,
              '0, '0, 1'b0);
      add_row(msta_pkg::MODE_PICK, 3'd7, '0, '0, 1, msta_pkg::ST_OK, STAMP_MAX, 32'h0,
              1'b0);
      add_row(MODE_UNKNOWN, 3'd5, STAMP_MAX, 32'hFFFF_FFFF, 1, msta_pkg::ST_OK,
              '0, '0, 1'b0);
      for (int i = 0; i < QDEPTH; i++)
         add_row(msta_pkg::MODE_INSERT, 3'd2, 48'(i), 32'(i * 3), 0, msta_pkg::ST_OK,
                 '0, '0, 1'b0);
      add_row(msta_pkg::MODE_INSERT, 3'd2, 48'd1000, 32'h0, 1, msta_pkg::ST_FULL,
              '0, '0, 1'b0);
      add_row(msta_pkg::MODE_REFRESH, 3'd0, '0, '0, 0, msta_pkg::ST_OK, '0, '0, 1'b0);
      foreach (directed_rows[i])
         send_item(directed_rows[i].mode, directed_rows[i].client,
                   directed_rows[i].stamp, directed_rows[i].pay,
                   directed_rows[i].typed, directed_rows[i].res);
      wait_drained();

      // Random phases, each with its own register setting
      for (int ph = 0; ph < 7; ph++) begin
         csr_write(msta_pkg::CSR_HALF_WINDOW, phase_hw[ph]);
         csr_write(msta_pkg::CSR_CLIENTS, {28'b0, phase_ciu[ph]});
         quiet = (ph == 6);
         base = msta_pkg::STAMP_W'({$urandom, $urandom}) & 48'hFFFF_FFF0_0000;
         for (int i = 0; i < NCLI; i++) last_stamp[i] = base + 48'($urandom_range(0, 50));
         if (ph == 2) hold_request = 1;
         for (int k = 0; k < RAND_PER_PHASE; k++) begin
            pick = $urandom_range(0, 99);
            c = msta_pkg::CLIENT_W'($urandom_range(0, NCLI - 1));
            if (ph == 1 || ph == 4) c = msta_pkg::CLIENT_W'($urandom_range(0, 1));
            stamp = '0;
            if (pick < 50) begin
               mode = msta_pkg::MODE_INSERT;
               if ($urandom_range(0, 9) == 0) begin
                  stamp = last_stamp[c] - 48'($urandom_range(0, 5));
               end else begin
                  stamp = last_stamp[c] + 48'($urandom_range(1, 40));
                  last_stamp[c] = stamp;
               end
            end else if (pick < 75) begin
               mode = msta_pkg::MODE_PICK;
            end else if (pick < 94) begin
               mode = msta_pkg::MODE_REFRESH;
            end else if (pick < 97) begin
               mode = MODE_UNKNOWN;
            end else begin
               // noise: arbitrary fields
               mode = msta_pkg::MODE_W'($urandom_range(0, 3));
               stamp = msta_pkg::STAMP_W'({$urandom, $urandom});
            end
            send_item(mode, c, stamp, $urandom, 0, '0);
            if (!quiet && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 8));
         end
         wait_drained();
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("run: %0d items, statuses ok/order/full/empty %0d/%0d/%0d/%0d",
               items_sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display("run: %0d stale heads dropped over 7 register settings", stale_total);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
